/* rtl/core/swmf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmf_pkg: shared types and constants of the median filter
// Field widths, register indexes, reset sizes and the queue item format.
// ----------------------------------------------------------------------------
package swmf_pkg;

  localparam int PIX_W       = 8;
  localparam int COLS_W      = 11;
  localparam int ROWS_W      = 12;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 1;
  localparam int ROW_W       = 14;
  localparam int POS_W       = 26;
  localparam int COLS_LIMIT  = 2047;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'b1;

  localparam logic [COLS_W-1:0] COLS_RESET = 11'd1024;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 12'd1024;

  typedef struct packed {
    logic [PIX_W-1:0]  value;
    logic [COLS_W-1:0] col;
    logic              emit;
    logic              interior;
    logic              last;
  } swmf_item_t;

endpackage

/* rtl/core/swmf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmf_front: input side of the median filter
// Holds the size registers and frame positions, tags each accepted item
// with its line column, emit, border and frame-end flags, and queues it.
// ----------------------------------------------------------------------------
module swmf_front #(
  parameter int WINDOW   = 3,
  parameter int MAX_COLS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [swmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swmf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           action,
  input  logic [swmf_pkg::PIX_W-1:0]     pixel_in,
  input  logic                           q_full,
  output logic                           q_push,
  output swmf_pkg::swmf_item_t           q_item
);
  import swmf_pkg::*;

  localparam int HALF    = WINDOW / 2;
  localparam int COL_CAP = (MAX_COLS < COLS_LIMIT) ? MAX_COLS : COLS_LIMIT;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_MUL,
    ST_SUM
  } state_t;

  state_t            state;
  logic [COLS_W-1:0] image_cols;
  logic [ROWS_W-1:0] image_rows;
  logic [COLS_W-1:0] cols_q;
  logic [ROWS_W-1:0] rows_q;
  logic [POS_W-1:0]  prod_in;
  logic [POS_W-1:0]  prod_out;
  logic [POS_W-1:0]  prod_tot;
  logic [POS_W-1:0]  total;
  logic [POS_W-1:0]  lag;
  logic [ROW_W-1:0]  in_row;
  logic [COLS_W-1:0] in_col;
  logic [ROW_W-1:0]  out_row;
  logic [COLS_W-1:0] out_col;
  logic [POS_W-1:0]  k;
  logic [POS_W-1:0]  p;

  logic [ROW_W-1:0]  in_row_next;
  logic [COLS_W-1:0] in_col_next;
  logic [ROW_W-1:0]  out_row_next;
  logic [COLS_W-1:0] out_col_next;
  logic [POS_W-1:0]  k_next;
  logic [POS_W-1:0]  p_next;

  logic [COLS_W-1:0] cols_eff;
  logic [ROWS_W-1:0] rows_eff;
  logic              accept;
  logic              k_below;
  logic              emit;
  logic              last;
  logic              interior;
  logic              in_wrap;
  logic              out_wrap;

  always_comb begin
    cols_eff = (image_cols == '0) ? COLS_W'(1) : image_cols;
    if (int'(cols_eff) > COL_CAP) begin
      cols_eff = COLS_W'(COL_CAP);
    end
    rows_eff = (image_rows == '0) ? ROWS_W'(1) : image_rows;
  end

  assign in_ready = (state == ST_RUN) && !q_full;
  assign accept   = in_valid && in_ready;

  assign k_below  = k < total;
  assign emit     = ({1'b0, p} + {1'b0, lag}) <= {1'b0, k};
  assign last     = ({1'b0, p} + (POS_W + 1)'(1)) >= {1'b0, total};
  assign interior = (out_row >= ROW_W'(HALF))
                 && (((ROW_W + 1)'(out_row) + (ROW_W + 1)'(HALF)) < (ROW_W + 1)'(rows_q))
                 && (out_col >= COLS_W'(HALF))
                 && (((COLS_W + 1)'(out_col) + (COLS_W + 1)'(HALF))
                     < (COLS_W + 1)'(cols_q));

  assign q_push         = accept;
  assign q_item.value   = (k_below && !action) ? pixel_in : '0;
  assign q_item.col     = in_col;
  assign q_item.emit    = emit;
  assign q_item.interior = interior;
  assign q_item.last    = last;

  assign in_wrap  = ((COLS_W + 1)'(in_col) + (COLS_W + 1)'(1)) >= (COLS_W + 1)'(cols_q);
  assign out_wrap = ((COLS_W + 1)'(out_col) + (COLS_W + 1)'(1)) >= (COLS_W + 1)'(cols_q);

  always_comb begin
    if (in_wrap) begin
      in_col_next = '0;
      in_row_next = in_row + ROW_W'(1);
      k_next      = k - POS_W'(in_col) + POS_W'(cols_q);
    end else begin
      in_col_next = in_col + COLS_W'(1);
      in_row_next = in_row;
      k_next      = k + POS_W'(1);
    end
    out_col_next = out_col;
    out_row_next = out_row;
    p_next       = p;
    if (emit) begin
      if (last) begin
        in_col_next  = '0;
        in_row_next  = '0;
        k_next       = '0;
        out_col_next = '0;
        out_row_next = '0;
        p_next       = '0;
      end else if (out_wrap) begin
        out_col_next = '0;
        out_row_next = out_row + ROW_W'(1);
        p_next       = p - POS_W'(out_col) + POS_W'(cols_q);
      end else begin
        out_col_next = out_col + COLS_W'(1);
        p_next       = p + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_MUL;
      image_cols <= COLS_RESET;
      image_rows <= ROWS_RESET;
      in_row     <= '0;
      in_col     <= '0;
      out_row    <= '0;
      out_col    <= '0;
      k          <= '0;
      p          <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_COLS: image_cols <= cfg_data[COLS_W-1:0];
        REG_IMAGE_ROWS: image_rows <= cfg_data[ROWS_W-1:0];
      endcase
      state <= ST_MUL;
    end else begin
      unique case (state)
        ST_MUL: begin
          cols_q   <= cols_eff;
          rows_q   <= rows_eff;
          prod_in  <= POS_W'(in_row) * POS_W'(cols_eff);
          prod_out <= POS_W'(out_row) * POS_W'(cols_eff);
          prod_tot <= POS_W'(rows_eff) * POS_W'(cols_eff);
          state    <= ST_SUM;
        end
        ST_SUM: begin
          k     <= prod_in + POS_W'(in_col);
          p     <= prod_out + POS_W'(out_col);
          total <= prod_tot;
          lag   <= POS_W'(cols_q) * POS_W'(HALF) + POS_W'(HALF);
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (accept) begin
            in_row  <= in_row_next;
            in_col  <= in_col_next;
            out_row <= out_row_next;
            out_col <= out_col_next;
            k       <= k_next;
            p       <= p_next;
          end
        end
        default: state <= ST_MUL;
      endcase
    end
  end

endmodule

/* rtl/core/swmf_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmf_queue: item queue between the front and back of the median filter
// Small first-in first-out buffer of tagged items; push and pop may coincide.
// ----------------------------------------------------------------------------
module swmf_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  swmf_pkg::swmf_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output swmf_pkg::swmf_item_t head
);
  import swmf_pkg::*;

  swmf_item_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = count == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

/* rtl/core/swmf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmf_back: execution side of the median filter
// Line memory delay chain, sliding window, pipelined odd-even transposition
// sorter and output register; the whole pipeline advances together.
// ----------------------------------------------------------------------------
module swmf_back #(
  parameter int WINDOW   = 3,
  parameter int MAX_COLS = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  swmf_pkg::swmf_item_t       q_item,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [swmf_pkg::PIX_W-1:0] pixel_out,
  output logic                       frame_last
);
  import swmf_pkg::*;

  localparam int HALF       = WINDOW / 2;
  localparam int SPAN       = 2 * HALF + 1;
  localparam int WIN_N      = SPAN * SPAN;
  localparam int MED_IDX    = (WINDOW * WINDOW) / 2;
  localparam int CENTER     = HALF * SPAN + HALF;
  localparam int LINES      = 2 * HALF;
  localparam int LINE_W     = LINES * PIX_W;
  localparam int LINE_DEPTH = (MAX_COLS < COLS_LIMIT) ? MAX_COLS : COLS_LIMIT;
  localparam int LA_W       = $clog2(LINE_DEPTH);

  logic              adv;
  logic [LINE_W-1:0] line_mem [LINE_DEPTH];
  logic [LINE_W-1:0] rd_q;
  logic [LINE_W-1:0] wr_data;
  logic [LA_W-1:0]   rd_addr;
  logic [LA_W-1:0]   wr_addr;
  logic              wr_en;

  logic              s1_vld;
  swmf_item_t        s1_item;

  logic [PIX_W-1:0]  column [SPAN];
  logic [PIX_W-1:0]  win [WIN_N];
  logic              w_vld;
  logic              w_int;
  logic              w_last;

  logic [PIX_W-1:0]  stg_in [WIN_N][WIN_N];
  logic [PIX_W-1:0]  stg_nx [WIN_N][WIN_N];
  logic [PIX_W-1:0]  sq [WIN_N][WIN_N];
  logic [PIX_W-1:0]  sc [WIN_N];
  logic [WIN_N-1:0]  sv;
  logic [WIN_N-1:0]  si;
  logic [WIN_N-1:0]  sl;

  assign adv     = !out_valid || out_ready;
  assign q_pop   = adv && q_valid;
  assign rd_addr = q_item.col[LA_W-1:0];
  assign wr_addr = s1_item.col[LA_W-1:0];
  assign wr_en   = adv && s1_vld;
  assign wr_data = {rd_q[LINE_W-PIX_W-1:0], s1_item.value};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    if (adv) begin
      rd_q <= (wr_en && (wr_addr == rd_addr)) ? wr_data : line_mem[rd_addr];
    end
  end

  always_comb begin
    for (int i = 0; i < LINES; i++) begin
      column[i] = rd_q[(LINES - 1 - i) * PIX_W +: PIX_W];
    end
    column[LINES] = s1_item.value;
  end

  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      stg_in[0][i] = win[i];
    end
    for (int s = 1; s < WIN_N; s++) begin
      for (int i = 0; i < WIN_N; i++) begin
        stg_in[s][i] = sq[s-1][i];
      end
    end
    for (int s = 0; s < WIN_N; s++) begin
      for (int i = 0; i < WIN_N; i++) begin
        if ((i % 2) == (s % 2)) begin
          if (i + 1 < WIN_N) begin
            stg_nx[s][i] = (stg_in[s][i] < stg_in[s][i+1]) ? stg_in[s][i] : stg_in[s][i+1];
          end else begin
            stg_nx[s][i] = stg_in[s][i];
          end
        end else begin
          if (i >= 1) begin
            stg_nx[s][i] = (stg_in[s][i-1] < stg_in[s][i]) ? stg_in[s][i] : stg_in[s][i-1];
          end else begin
            stg_nx[s][i] = stg_in[s][i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld    <= 1'b0;
      w_vld     <= 1'b0;
      sv        <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_vld    <= q_valid;
      w_vld     <= s1_vld && s1_item.emit;
      sv        <= {sv[WIN_N-2:0], w_vld};
      out_valid <= sv[WIN_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item <= q_item;
      w_int   <= s1_item.interior;
      w_last  <= s1_item.last;
      if (s1_vld) begin
        for (int i = 0; i < SPAN; i++) begin
          for (int j = 0; j < SPAN; j++) begin
            win[i*SPAN+j] <= (j == SPAN - 1) ? column[i] : win[i*SPAN+j+1];
          end
        end
      end
      for (int s = 0; s < WIN_N; s++) begin
        for (int i = 0; i < WIN_N; i++) begin
          sq[s][i] <= stg_nx[s][i];
        end
      end
      sc[0] <= win[CENTER];
      for (int s = 1; s < WIN_N; s++) begin
        sc[s] <= sc[s-1];
      end
      si         <= {si[WIN_N-2:0], w_int};
      sl         <= {sl[WIN_N-2:0], w_last};
      pixel_out  <= si[WIN_N-1] ? sq[WIN_N-1][MED_IDX] : sc[WIN_N-1];
      frame_last <= sl[WIN_N-1];
    end
  end

endmodule

/* rtl/core/sliding_window_median_filter.sv */
// Result path: the item that completes a result's window is queued, then passes the input
//   register, window register, S*S sorter stages and output register, S = 2*(WINDOW/2)+1;
//   that item comes (WINDOW/2)*cols + WINDOW/2 items after the source pixel.
// Throughput: one item per cycle unless stalled, from the fully pipelined S*S-stage sorter.
// A configuration write holds off input through the ST_MUL and ST_SUM rebuild states.
// Reset: synchronous; clears counters and valids, loads 1024 x 1024, then ST_MUL, ST_SUM.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_median_filter: streaming square-window median filter
// Raster-order 8-bit pixels in, median-filtered raster-order pixels out,
// border pixels copied, final pixel of each frame marked.
// ----------------------------------------------------------------------------
module sliding_window_median_filter #(
  parameter int WINDOW   = 3,
  parameter int MAX_COLS = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [swmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swmf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           action,
  input  logic [swmf_pkg::PIX_W-1:0]     pixel_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [swmf_pkg::PIX_W-1:0]     pixel_out,
  output logic                           frame_last
);
  import swmf_pkg::*;

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  swmf_item_t q_item;
  swmf_item_t q_head;

  swmf_front #(
    .WINDOW   (WINDOW),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .pixel_in  (pixel_in),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  swmf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  swmf_back #(
    .WINDOW   (WINDOW),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_out  (pixel_out),
    .frame_last (frame_last)
  );

`ifndef ASSERT_OFF
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_write |-> ##1 !in_ready ##1 !in_ready)
    else $error("input accepted while positions are rebuilt");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("transfer pushed into a full queue");
`endif

endmodule

/* bench/tb_sliding_window_median_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_median_filter: self-checking bench for the median filter
// Streams raster frames through the filter under random flow control on both
// sides and compares every output transfer against an in-bench 3x3 median
// predictor. Covers small and degenerate image sizes.
// ----------------------------------------------------------------------------
module tb_sliding_window_median_filter;

  import swmf_pkg::*;

  localparam int WINDOW       = 3;
  localparam int MAX_COLS     = 1024;
  localparam int HALF         = WINDOW / 2;
  localparam int SPAN         = 2 * HALF + 1;
  localparam int HIST         = 2 * HALF * MAX_COLS + 2 * HALF + 1;
  localparam int SETTLE       = 24;
  localparam int STALL_LIMIT  = 5000;
  localparam int RANDOM_ITEMS = 1650;
  localparam int SQUEEZE_AT   = 200;
  localparam int SQUEEZE_LEN  = 400;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct packed {
    logic             flush;
    logic [PIX_W-1:0] pix;
  } pixel_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } filtered_px_t;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 cfg_write  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = REG_IMAGE_COLS;
  logic [CFG_W-1:0]     cfg_data   = '0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic                 action     = ACT_PIXEL;
  logic [PIX_W-1:0]     pixel_in   = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic [PIX_W-1:0]     pixel_out;
  logic                 frame_last;

  pixel_item_t  pixel_stream_q[$];
  filtered_px_t filtered_q[$];

  logic [PIX_W-1:0]  px_hist [HIST];
  logic [COLS_W-1:0] img_cols = COLS_RESET;
  logic [ROWS_W-1:0] img_rows = ROWS_RESET;
  int unsigned src_row = 0, src_col = 0, dst_row = 0, dst_col = 0;

  int unsigned items_pushed  = 0;
  int unsigned items_taken   = 0;
  int unsigned items_offered = 0;
  int unsigned tx_gap        = 0;
  int unsigned tx_mode       = 0;
  int unsigned rx_gap        = 0;
  int unsigned rx_hold       = 0;
  int unsigned rx_mode       = 0;
  int unsigned results_seen  = 0;
  int unsigned idle_cycles   = 0;
  int unsigned error_count   = 0;

  sliding_window_median_filter #(
    .WINDOW  (WINDOW),
    .MAX_COLS(MAX_COLS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .pixel_in  (pixel_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_out (pixel_out),
    .frame_last(frame_last)
  );

  always #10 clk = ~clk;

  function automatic int unsigned active_cols();
    int unsigned c;
    c = (img_cols == 0) ? 1 : img_cols;
    return (c > MAX_COLS) ? MAX_COLS : c;
  endfunction

  function automatic int unsigned active_rows();
    return (img_rows == 0) ? 1 : img_rows;
  endfunction

  function automatic int unsigned pause_draw(input int unsigned mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 16);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  task automatic log_mismatch(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    error_count++;
  endtask

  // Advance the frame position for one accepted item and queue any pixel it releases.
  task automatic filter_predict(input logic flush, input logic [PIX_W-1:0] px);
    int unsigned  cols, rows, total, lag, k, p, r, c, n, j;
    logic [PIX_W-1:0] win [SPAN*SPAN];
    logic [PIX_W-1:0] v;
    filtered_px_t res;
    cols  = active_cols();
    rows  = active_rows();
    total = rows * cols;
    lag   = HALF * cols + HALF;
    k     = src_row * cols + src_col;
    if (k < total) px_hist[k % HIST] = (flush == ACT_FLUSH) ? '0 : px;
    src_col++;
    if (src_col >= cols) begin
      src_col = 0;
      src_row++;
    end
    p = dst_row * cols + dst_col;
    if (p + lag > k) return;
    r = dst_row;
    c = dst_col;
    if (r >= HALF && r + HALF < rows && c >= HALF && c + HALF < cols) begin
      n = 0;
      for (int unsigned i = 0; i < SPAN; i++) begin
        for (int unsigned m = 0; m < SPAN; m++) begin
          win[n] = px_hist[((r + i - HALF) * cols + (c + m - HALF)) % HIST];
          n++;
        end
      end
      for (int unsigned i = 1; i < SPAN * SPAN; i++) begin
        v = win[i];
        j = i;
        while (j > 0 && win[j-1] > v) begin
          win[j] = win[j-1];
          j--;
        end
        win[j] = v;
      end
      res.pix = win[(SPAN * SPAN) / 2];
    end else begin
      res.pix = px_hist[p % HIST];
    end
    res.last = (p + 1 >= total);
    filtered_q = {filtered_q, res};
    if (res.last) begin
      src_row = 0;
      src_col = 0;
      dst_row = 0;
      dst_col = 0;
    end else begin
      dst_col++;
      if (dst_col >= cols) begin
        dst_col = 0;
        dst_row++;
      end
    end
  endtask

  task automatic push_item(input logic flush, input logic [PIX_W-1:0] px);
    pixel_item_t it;
    it.flush = flush;
    it.pix   = px;
    pixel_stream_q = {pixel_stream_q, it};
    items_pushed++;
  endtask

  // Queue one whole frame plus its flush ticks at the current size.
  task automatic queue_frame(input bit noisy, output int unsigned n);
    int unsigned total, lag;
    logic        fl;
    logic [PIX_W-1:0] px;
    total = active_rows() * active_cols();
    lag   = HALF * active_cols() + HALF;
    n     = total + lag;
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy) fl = 1'($urandom_range(0, 1));
      else if (i < total) fl = ($urandom_range(0, 31) == 0) ? ACT_FLUSH : ACT_PIXEL;
      else fl = ($urandom_range(0, 15) == 0) ? ACT_PIXEL : ACT_FLUSH;
      case ($urandom_range(0, 3))
        0:       px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        1:       px = PIX_W'(100 + $urandom_range(0, 3));
        default: px = PIX_W'($urandom_range(0, 255));
      endcase
      push_item(fl, px);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_IMAGE_COLS) img_cols = data[COLS_W-1:0];
    else img_rows = data[ROWS_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic settle_idle();
    while (items_taken != items_pushed || filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_size(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
    settle_idle();
    write_reg(REG_IMAGE_COLS, cols);
    write_reg(REG_IMAGE_ROWS, rows);
  endtask

  // Sender: offer queued items with a random pause after each transfer.
  always @(posedge clk) begin : drive_pixels
    pixel_item_t nxt;
    logic        fire;
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        filter_predict(action, pixel_in);
        items_taken++;
      end
      if (!in_valid || fire) begin
        if (tx_gap != 0) begin
          tx_gap   <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pixel_stream_q.size() != 0) begin
          nxt = pixel_stream_q.pop_front();
          action   <= nxt.flush;
          pixel_in <= nxt.pix;
          in_valid <= 1'b1;
          tx_gap   <= pause_draw(tx_mode);
          if (items_offered % 64 == 63) tx_mode <= $urandom_range(0, 2);
          items_offered++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random pause after each transfer, one long hold to back up the pipe.
  always @(posedge clk) begin : accept_results
    int unsigned gap_n, hold_n;
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap    <= 0;
      rx_hold   <= 0;
    end else begin
      gap_n  = rx_gap;
      hold_n = rx_hold;
      if (hold_n != 0) hold_n--;
      if (out_valid && out_ready) begin
        results_seen++;
        if (results_seen % 64 == 0) rx_mode = $urandom_range(0, 2);
        gap_n = pause_draw(rx_mode);
        if (results_seen == SQUEEZE_AT) hold_n = SQUEEZE_LEN;
      end else if (gap_n != 0) begin
        gap_n--;
      end
      rx_gap    <= gap_n;
      rx_hold   <= hold_n;
      out_ready <= (gap_n == 0) && (hold_n == 0);
    end
  end

  always @(posedge clk) begin : check_results
    filtered_px_t want;
    if (!rst && out_valid && out_ready) begin
      if (filtered_q.size() == 0) begin
        log_mismatch($sformatf("unexpected output pixel_out=%0d frame_last=%0b",
                               pixel_out, frame_last));
      end else begin
        want = filtered_q.pop_front();
        if (pixel_out !== want.pix)
          log_mismatch($sformatf("pixel_out %0d, expected %0d", pixel_out, want.pix));
        if (frame_last !== want.last)
          log_mismatch($sformatf("frame_last %0b, expected %0b", frame_last, want.last));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("TIMEOUT: no transfer for %0d cycles", idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned       n;
    int unsigned       rand_items;
    logic [COLS_W-1:0] cols_pick;
    logic [ROWS_W-1:0] rows_pick;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // 3x3 frame: extremes, a flush tick inside the frame, a pixel among the flush ticks
    set_size(3, 3);
    push_item(ACT_PIXEL, 8'hFF);
    push_item(ACT_PIXEL, 8'h00);
    push_item(ACT_PIXEL, 8'hFF);
    push_item(ACT_PIXEL, 8'h00);
    push_item(ACT_FLUSH, 8'h7E);
    push_item(ACT_PIXEL, 8'hFF);
    push_item(ACT_PIXEL, 8'h80);
    push_item(ACT_PIXEL, 8'hFF);
    push_item(ACT_PIXEL, 8'h01);
    push_item(ACT_FLUSH, 8'h00);
    push_item(ACT_PIXEL, 8'hAA);
    push_item(ACT_FLUSH, 8'hFF);
    push_item(ACT_FLUSH, 8'h55);

    // zero sizes act as one
    set_size(0, 0);
    push_item(ACT_PIXEL, 8'hC3);
    push_item(ACT_FLUSH, 8'h00);
    push_item(ACT_FLUSH, 8'hFF);

    // image smaller than the window: border only
    set_size(2, 2);
    push_item(ACT_PIXEL, 8'h01);
    push_item(ACT_PIXEL, 8'hFE);
    push_item(ACT_PIXEL, 8'h7F);
    push_item(ACT_PIXEL, 8'h80);
    push_item(ACT_FLUSH, 8'h00);
    push_item(ACT_FLUSH, 8'h00);
    push_item(ACT_FLUSH, 8'h00);

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items == 0 || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       cols_pick = 0;
          1:       cols_pick = COLS_W'($urandom_range(9, 40));
          2:       cols_pick = COLS_W'($urandom_range(1, 2));
          default: cols_pick = COLS_W'($urandom_range(3, 8));
        endcase
        case ($urandom_range(0, 9))
          0:       rows_pick = 0;
          1:       rows_pick = ROWS_W'($urandom_range(8, 14));
          default: rows_pick = ROWS_W'($urandom_range(1, 6));
        endcase
        set_size({1'($urandom_range(0, 1)), cols_pick}, rows_pick);
      end
      queue_frame($urandom_range(0, 3) == 0, n);
      rand_items += n;
    end

    settle_idle();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
